@@ sv/assert_macros.svh @@
// assertion macros shared by the debouncer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define BDEL_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// same-cycle implication checked outside reset
`define BDEL_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ sv/bdel_pkg.sv @@
// shared types and constants for the button debouncer with event latch
package bdel_pkg;

  localparam int NUM_BUTTONS = 2;
  localparam int CNT_W       = 8;
  localparam int FUNC_W      = 3;

  localparam logic [CNT_W-1:0] SETTLE_RESET = CNT_W'(10);
  localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_TICK        = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_RD_CHANGED  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RD_PRESSED  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RD_RELEASED = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RD_STATUS   = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]      func;
    logic [NUM_BUTTONS-1:0] pin_levels;
  } in_item_t;

  typedef struct packed {
    logic                   notify;
    logic [NUM_BUTTONS-1:0] notify_mask;
    logic [NUM_BUTTONS-1:0] read_data;
  } out_item_t;

  // accepted level change of one button on a tick
  typedef struct packed {
    logic press;
    logic release_evt;
  } btn_evt_t;

endpackage

@@ sv/bdel_button.sv @@
// settle counter and debounced level of one button
module bdel_button
  import bdel_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             tick_en,
  input  logic             pin,
  input  logic [CNT_W-1:0] settle_count,
  output logic             level,
  output btn_evt_t         evt
);

  logic [CNT_W-1:0] counter;
  logic [CNT_W-1:0] counter_next;
  logic             level_next;

  // counter runs while the pin differs from the debounced level
  always_comb begin
    counter_next = counter;
    level_next   = level;
    evt          = '0;
    if (tick_en) begin
      if (pin == level) begin
        counter_next = '0;
      end else if (counter >= settle_count) begin
        counter_next    = '0;
        level_next      = pin;
        evt.press       = pin;
        evt.release_evt = ~pin;
      end else if (counter != CNT_MAX) begin
        counter_next = counter + CNT_W'(1);
      end
    end
  end

  // lane state
  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      level   <= 1'b0;
    end else begin
      counter <= counter_next;
      level   <= level_next;
    end
  end

endmodule

@@ sv/button_debouncer_event_latch.sv @@
// Debouncer for NUM_BUTTONS push buttons with sticky press/release event flags.
// Input channel (in_valid, in_stall, in_data): one beat is a tick sample or a
// read. A tick runs each button's settle counter against the raw pin level and
// updates pressed/released/changed flags; reads return changed, pressed or
// released flags (and clear that set) or the debounced levels.
// Output channel (out_valid, out_stall, out_data): exactly one beat per input
// beat, in order. notify is set on a tick that leaves any changed bit set.
// Config channel (cfg_valid, cfg_ready, cfg_data): writes settle_count; always
// ready; write only while no beat is in flight.
// Path: an accepted beat waits in the input register; the result register and
// out_valid load from it when the output is empty or not stalled.
// Throughput: one beat per cycle while the output is not stalled; all
// per-button logic sits in the single stage between the two registers.
// Stall: while out_stall holds a result, one more beat is taken into the input
// register; after that in_stall rises until the output moves.
// Reset (rst, synchronous): flags, levels and counters clear, settle_count
// returns to 10, both channels empty.
`include "assert_macros.svh"

module button_debouncer_event_latch
  import bdel_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  logic [CNT_W-1:0]       settle_count;
  logic                   inbuf_valid;
  in_item_t               inbuf;
  logic                   advance;
  logic                   go;
  logic                   tick_en;
  logic [NUM_BUTTONS-1:0] levels;
  btn_evt_t [NUM_BUTTONS-1:0] evts;
  logic [NUM_BUTTONS-1:0] press_vec;
  logic [NUM_BUTTONS-1:0] release_vec;
  logic [NUM_BUTTONS-1:0] pressed_flags;
  logic [NUM_BUTTONS-1:0] released_flags;
  logic [NUM_BUTTONS-1:0] changed_flags;
  logic [NUM_BUTTONS-1:0] pressed_flags_next;
  logic [NUM_BUTTONS-1:0] released_flags_next;
  logic [NUM_BUTTONS-1:0] changed_flags_next;
  out_item_t              result;

  // config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_count <= SETTLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      settle_count <= cfg_data;
    end
  end

  // pipeline flow control
  assign advance  = !out_valid || !out_stall;
  assign in_stall = inbuf_valid && !advance;
  assign go       = inbuf_valid && advance;
  assign tick_en  = go && (inbuf.func == FUNC_TICK);

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      inbuf_valid <= 1'b0;
    end else if (!in_stall) begin
      inbuf_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      inbuf <= in_data;
    end
  end

  // per-button debounce lanes
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    bdel_button u_button (
      .clk          (clk),
      .rst          (rst),
      .tick_en      (tick_en),
      .pin          (inbuf.pin_levels[i]),
      .settle_count (settle_count),
      .level        (levels[i]),
      .evt          (evts[i])
    );
    assign press_vec[i]   = evts[i].press;
    assign release_vec[i] = evts[i].release_evt;
  end

  // flag update and result for the beat in the input register
  always_comb begin
    pressed_flags_next  = pressed_flags;
    released_flags_next = released_flags;
    changed_flags_next  = changed_flags;
    result              = '0;
    if (go) begin
      unique case (inbuf.func)
        FUNC_TICK: begin
          pressed_flags_next  = (pressed_flags | press_vec) & ~release_vec;
          released_flags_next = (released_flags | release_vec) & ~press_vec;
          changed_flags_next  = pressed_flags_next | released_flags_next;
          result.notify_mask  = changed_flags_next;
          result.notify       = |changed_flags_next;
        end
        FUNC_RD_CHANGED: begin
          result.read_data   = changed_flags;
          changed_flags_next = '0;
        end
        FUNC_RD_PRESSED: begin
          result.read_data   = pressed_flags;
          pressed_flags_next = '0;
        end
        FUNC_RD_RELEASED: begin
          result.read_data    = released_flags;
          released_flags_next = '0;
        end
        FUNC_RD_STATUS: begin
          result.read_data = levels;
        end
        default: begin
          result = '0;
        end
      endcase
    end
  end

  // sticky event flags
  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_flags  <= '0;
      released_flags <= '0;
      changed_flags  <= '0;
    end else begin
      pressed_flags  <= pressed_flags_next;
      released_flags <= released_flags_next;
      changed_flags  <= changed_flags_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= inbuf_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_data <= result;
    end
  end

  // checks
  `BDEL_ASSERT_ALWAYS(a_flags_exclusive, (pressed_flags & released_flags) == '0, "both flags set")
  `BDEL_ASSERT_IMPLY(a_notify, out_valid, out_data.notify == |out_data.notify_mask, "bad notify")
  `BDEL_ASSERT_IMPLY(a_stall_full, in_stall, inbuf_valid && out_valid, "stall while empty")

endmodule

@@ bench/tb_button_debouncer_event_latch.sv @@
// self-checking testbench for the button debouncer with sticky event flags
module tb_button_debouncer_event_latch;
  import bdel_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = FUNC_RD_STATUS + FUNC_W'(1);
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = {FUNC_W{1'b1}};
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned STALL_LIMIT  = 400;
  localparam int unsigned LONG_HOLD    = 48;
  localparam int unsigned HOLD_AT      = 400;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  button_debouncer_event_latch u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // button state as the block should hold it
  logic [CNT_W-1:0]       settle = SETTLE_RESET;
  logic [NUM_BUTTONS-1:0] level = '0;
  logic [CNT_W-1:0]       counter [NUM_BUTTONS] = '{default: '0};
  logic [NUM_BUTTONS-1:0] pressed = '0;
  logic [NUM_BUTTONS-1:0] released = '0;
  logic [NUM_BUTTONS-1:0] changed = '0;

  in_item_t    button_beats [$];
  out_item_t   due_reports [$];
  bit          steady = 1'b0;
  int unsigned in_gap = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned beats_sent = 0;
  int unsigned reports_seen = 0;
  int unsigned settle_writes = 0;
  int unsigned press_events = 0;
  int unsigned release_events = 0;
  int unsigned mismatches = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // run one beat through the debounce state and return its report
  function automatic out_item_t debounce_step(in_item_t beat);
    out_item_t rep;
    int b;
    rep = '0;
    case (beat.func)
      FUNC_TICK: begin
        for (b = 0; b < NUM_BUTTONS; b++) begin
          if (beat.pin_levels[b] == level[b]) begin
            counter[b] = '0;
          end else if (counter[b] >= settle) begin
            counter[b] = '0;
            level[b] = beat.pin_levels[b];
            pressed[b] = beat.pin_levels[b];
            released[b] = ~beat.pin_levels[b];
            if (beat.pin_levels[b]) press_events++;
            else release_events++;
          end else if (counter[b] != CNT_MAX) begin
            counter[b] = counter[b] + CNT_W'(1);
          end
        end
        changed = pressed | released;
        rep.notify_mask = changed;
        rep.notify = |changed;
      end
      FUNC_RD_CHANGED: begin
        rep.read_data = changed;
        changed = '0;
      end
      FUNC_RD_PRESSED: begin
        rep.read_data = pressed;
        pressed = '0;
      end
      FUNC_RD_RELEASED: begin
        rep.read_data = released;
        released = '0;
      end
      FUNC_RD_STATUS: begin
        rep.read_data = level;
      end
      default: ;
    endcase
    return rep;
  endfunction

  // input driver: one beat at a time from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        due_reports.push_back(debounce_step(in_data));
        beats_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (button_beats.size() != 0) begin
          in_data <= button_beats.pop_front();
          in_valid <= 1'b1;
          in_gap <= steady ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // compare one report against the oldest prediction
  task automatic check_report(input out_item_t got);
    out_item_t want;
    if (due_reports.size() == 0) begin
      $error("report with nothing predicted: %p", got);
      mismatches++;
    end else begin
      want = due_reports.pop_front();
      if (got.notify !== want.notify) begin
        $error("notify: expected %0b, got %0b", want.notify, got.notify);
        mismatches++;
      end
      if (got.notify_mask !== want.notify_mask) begin
        $error("notify_mask: expected %b, got %b", want.notify_mask, got.notify_mask);
        mismatches++;
      end
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %b, got %b", want.read_data, got.read_data);
        mismatches++;
      end
    end
  endtask

  // output monitor with random back-pressure and one long hold-off
  always @(posedge clk) begin
    int unsigned wait_n;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      wait_n = stall_left;
      if (out_valid && !out_stall) begin
        check_report(out_data);
        reports_seen++;
        wait_n = steady ? 0 : $urandom_range(0, 3);
        if (reports_seen == HOLD_AT) wait_n = LONG_HOLD;
      end
      if (wait_n != 0) begin
        out_stall <= 1'b1;
        stall_left <= wait_n - 1;
      end else begin
        out_stall <= 1'b0;
        stall_left <= 0;
      end
    end
  end

  // watchdog on cycles with no beat moving on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_beat(input logic [FUNC_W-1:0] f, input logic [NUM_BUTTONS-1:0] p);
    in_item_t beat;
    beat.func = f;
    beat.pin_levels = p;
    button_beats.push_back(beat);
  endtask

  task automatic queue_ticks(input int unsigned n, input logic [NUM_BUTTONS-1:0] p);
    repeat (n) queue_beat(FUNC_TICK, p);
  endtask

  task automatic wait_idle();
    while (button_beats.size() != 0 || in_valid || due_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_settle(input logic [CNT_W-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    settle = v;
    settle_writes++;
    cfg_valid <= 1'b0;
  endtask

  // pin levels held long enough to settle while the settle count is at most 20, with bounces, reads and junk mixed in
  task automatic queue_presses(input int unsigned n);
    int unsigned made;
    int unsigned hold;
    int unsigned pick;
    logic [NUM_BUTTONS-1:0] target;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        queue_beat(FUNC_W'($urandom_range(0, FUNC_SPARE_LAST)),
                   NUM_BUTTONS'($urandom_range(0, 3)));
        made++;
      end else if (pick < 25) begin
        queue_beat(FUNC_W'($urandom_range(FUNC_RD_CHANGED, FUNC_RD_STATUS)),
                   NUM_BUTTONS'($urandom_range(0, 3)));
        made++;
      end else begin
        target = NUM_BUTTONS'($urandom_range(0, 3));
        hold = (settle > 20) ? $urandom_range(1, 20) : settle + $urandom_range(0, 3);
        repeat (hold + 1) begin
          if ($urandom_range(0, 9) == 0) queue_beat(FUNC_TICK, NUM_BUTTONS'($urandom_range(0, 3)));
          else queue_beat(FUNC_TICK, target);
          made++;
        end
      end
    end
  endtask

  initial begin
    logic [NUM_BUTTONS-1:0] flip;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset values: reads see nothing, spare codes do nothing
    queue_beat(FUNC_RD_CHANGED, 2'b11);
    queue_beat(FUNC_RD_PRESSED, 2'b11);
    queue_beat(FUNC_RD_RELEASED, 2'b11);
    queue_beat(FUNC_RD_STATUS, 2'b11);
    queue_beat(FUNC_SPARE_FIRST, 2'b11);
    queue_beat(FUNC_SPARE_FIRST + FUNC_W'(1), 2'b01);
    queue_beat(FUNC_SPARE_LAST, 2'b10);
    // a bounce restarts the count, then a full settle presses both
    queue_ticks(3, 2'b11);
    queue_ticks(1, 2'b00);
    queue_ticks(11, 2'b11);
    queue_beat(FUNC_RD_CHANGED, 2'b00);
    queue_beat(FUNC_RD_PRESSED, 2'b00);
    queue_beat(FUNC_RD_RELEASED, 2'b00);
    queue_beat(FUNC_RD_STATUS, 2'b00);
    queue_presses(80);

    // settle count of zero: first differing sample is taken
    write_settle('0);
    steady = 1'b1;
    flip = ~level;
    queue_ticks(1, flip);
    queue_beat(FUNC_RD_RELEASED, 2'b00);
    queue_beat(FUNC_RD_CHANGED, 2'b00);
    queue_ticks(1, flip);
    queue_presses(60);

    // largest settle count, then a lowered count below a running counter
    write_settle(CNT_MAX);
    steady = 1'b0;
    flip = ~level;
    queue_ticks(258, flip);
    queue_beat(FUNC_RD_STATUS, 2'b00);
    queue_ticks(6, ~flip);
    write_settle(8'd1);
    queue_ticks(1, ~level);
    queue_beat(FUNC_RD_CHANGED, 2'b00);
    queue_beat(FUNC_RD_STATUS, 2'b00);
    queue_presses(70);

    write_settle(CNT_W'($urandom_range(2, 12)));
    queue_presses(70);

    write_settle(SETTLE_RESET);
    queue_presses(70);

    wait_idle();
    $display("%0d beats driven, %0d reports checked over %0d settle count writes",
             beats_sent, reports_seen, settle_writes);
    $display("%0d presses and %0d releases latched, %0d mismatches",
             press_events, release_events, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
